/* design/mm3_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_pkg: shared types and constants for the MurmurHash3 x86_32 engine
// Mixing constants, rotate amounts, and the item record that travels from the
// front end through the queue to the hash back end.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

  localparam int unsigned ROT_K   = 15;
  localparam int unsigned ROT_H   = 13;
  localparam int unsigned FIN_SH1 = 16;
  localparam int unsigned FIN_SH2 = 13;

  localparam int unsigned WORD_BYTES = 4;

  // how a word enters the running hash
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_FULL
  } kind_t;

  typedef struct packed {
    logic [31:0] k;
    kind_t       kind;
    logic [2:0]  len_add;
    logic        last;
  } item_t;

  function automatic logic [31:0] rotl_k(input logic [31:0] x);
    rotl_k = (x << ROT_K) | (x >> (32 - ROT_K));
  endfunction

  function automatic logic [31:0] rotl_h(input logic [31:0] x);
    rotl_h = (x << ROT_H) | (x >> (32 - ROT_H));
  endfunction

endpackage
`default_nettype wire

/* design/mm3_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mm3 channel interfaces
// Valid/ready channels for message words, hash results and seed writes.
// ----------------------------------------------------------------------------
interface mm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last,
                  output ready);
endinterface

interface mm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

interface mm3_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface
`default_nettype wire

/* design/mm3_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_front: input classification and block scramble
// Two-stage pipeline: classify and mask the word, multiply by C1; then rotate
// and multiply by C2. The scrambled block does not depend on the hash.
// ----------------------------------------------------------------------------
module mm3_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  mm3_in_if.sink             in_ch,
  output mm3_pkg::item_t     push_item,
  output logic               push_valid,
  input  wire logic          push_ready
);

  logic           s1_v_r;
  logic           s2_v_r;
  mm3_pkg::item_t s1_r;
  mm3_pkg::item_t s2_r;
  mm3_pkg::item_t s1_nxt;
  mm3_pkg::item_t s2_nxt;
  logic           adv;
  logic [31:0]    masked;

  // whole pipe moves when the output stage is empty or draining
  assign adv          = !s2_v_r || push_ready;
  assign in_ch.ready  = adv;
  assign push_valid   = s2_v_r;
  assign push_item    = s2_r;

  // classify the beat and mask off unused tail bytes
  always_comb begin
    masked         = in_ch.data_word;
    s1_nxt.last    = in_ch.last;
    if (!in_ch.last || in_ch.byte_count >= 3'(mm3_pkg::WORD_BYTES)) begin
      s1_nxt.kind    = mm3_pkg::KIND_FULL;
      s1_nxt.len_add = 3'(mm3_pkg::WORD_BYTES);
    end else if (in_ch.byte_count != 3'd0) begin
      s1_nxt.kind    = mm3_pkg::KIND_TAIL;
      s1_nxt.len_add = in_ch.byte_count;
      unique case (in_ch.byte_count)
        3'd1:    masked = in_ch.data_word & 32'h0000_00ff;
        3'd2:    masked = in_ch.data_word & 32'h0000_ffff;
        default: masked = in_ch.data_word & 32'h00ff_ffff;
      endcase
    end else begin
      s1_nxt.kind    = mm3_pkg::KIND_NONE;
      s1_nxt.len_add = 3'd0;
    end
    s1_nxt.k = masked * mm3_pkg::MIX_C1;
  end

  // second half of the scramble
  always_comb begin
    s2_nxt   = s1_r;
    s2_nxt.k = mm3_pkg::rotl_k(s1_r.k) * mm3_pkg::MIX_C2;
  end

  // advance pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
    end
  end

  // advance pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/mm3_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_queue: short FIFO between front end and hash back end
// Small register file with push and pop handshakes; read is direct.
// ----------------------------------------------------------------------------
module mm3_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire mm3_pkg::item_t  push_item,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output mm3_pkg::item_t       pop_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mm3_pkg::item_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  // write entry at tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* design/mm3_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_back: running hash update and finalization
// Folds one scrambled block per cycle into the hash while in ST_MIX; on the
// final beat runs the avalanche in ST_FM1-ST_FM3 and loads the output register.
// ----------------------------------------------------------------------------
module mm3_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [31:0]     seed,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire mm3_pkg::item_t  pop_item,
  mm3_out_if.source            out_ch
);

  typedef enum logic [1:0] {
    ST_MIX,
    ST_FM1,
    ST_FM2,
    ST_FM3
  } state_t;

  state_t      state_r;
  logic [31:0] hash_r;
  logic [31:0] len_r;
  logic        at_start_r;
  logic [31:0] fin_r;
  logic        out_valid_r;
  logic [31:0] out_hash_r;

  logic [31:0] h_base;
  logic [31:0] len_base;
  logic [31:0] h_rot;
  logic [31:0] hash_nxt;
  logic [31:0] len_nxt;
  logic        take;
  logic        out_free;

  assign pop_ready         = state_r == ST_MIX;
  assign take              = pop_valid && pop_ready;
  assign out_free          = !out_valid_r || out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

  // fold the block into the running hash
  always_comb begin
    h_base   = at_start_r ? seed : hash_r;
    len_base = at_start_r ? 32'd0 : len_r;
    h_rot    = mm3_pkg::rotl_h(h_base ^ pop_item.k);
    len_nxt  = len_base + 32'(pop_item.len_add);
    unique case (pop_item.kind)
      mm3_pkg::KIND_FULL: hash_nxt = h_rot + {h_rot[29:0], 2'b00} + mm3_pkg::MIX_ADD;
      mm3_pkg::KIND_TAIL: hash_nxt = h_base ^ pop_item.k;
      default:            hash_nxt = h_base;
    endcase
  end

  // sequence mixing, avalanche steps and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_MIX;
      hash_r      <= '0;
      len_r       <= '0;
      at_start_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != ST_FM3)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_MIX: begin
          if (take) begin
            if (pop_item.last) begin
              fin_r      <= hash_nxt ^ len_nxt;
              hash_r     <= '0;
              len_r      <= '0;
              at_start_r <= 1'b1;
              state_r    <= ST_FM1;
            end else begin
              hash_r     <= hash_nxt;
              len_r      <= len_nxt;
              at_start_r <= 1'b0;
            end
          end
        end
        ST_FM1: begin
          fin_r   <= (fin_r ^ (fin_r >> mm3_pkg::FIN_SH1)) * mm3_pkg::FIN_C1;
          state_r <= ST_FM2;
        end
        ST_FM2: begin
          fin_r   <= (fin_r ^ (fin_r >> mm3_pkg::FIN_SH2)) * mm3_pkg::FIN_C2;
          state_r <= ST_FM3;
        end
        ST_FM3: begin
          // hold until the output register can take the result
          if (out_free) begin
            out_hash_r  <= fin_r ^ (fin_r >> mm3_pkg::FIN_SH1);
            out_valid_r <= 1'b1;
            state_r     <= ST_MIX;
          end
        end
        default: state_r <= ST_MIX;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/murmur3_32_hash.sv */
`default_nettype none
// A final beat passes s1, s2, the queue and ST_FM1, ST_FM2, ST_FM3 to out_ch.valid.
// Throughput: one word per cycle unless stalled; a message's final beat holds the
// hash unit for its fold plus three avalanche steps (ST_FM1, ST_FM2, ST_FM3).
// The queue lets the next message's words enter while a result is finalized.
// Reset (rst_n low, synchronous) clears pipeline valids, queue, hash state and seed.
// ----------------------------------------------------------------------------
// murmur3_32_hash: streaming MurmurHash3 x86_32 engine
// Front end scrambles words, a queue decouples it from the hash back end.
// ----------------------------------------------------------------------------
module murmur3_32_hash #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mm3_in_if.sink    in_ch,
  mm3_out_if.source out_ch,
  mm3_cfg_if.sink   cfg_ch
);

  logic [31:0]    seed_r;
  mm3_pkg::item_t fq_item;
  logic           fq_valid;
  logic           fq_ready;
  mm3_pkg::item_t qb_item;
  logic           qb_valid;
  logic           qb_ready;

  assign cfg_ch.ready = 1'b1;

  // hold the seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_ch.valid) begin
      seed_r <= cfg_ch.seed;
    end
  end

  mm3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_item  (fq_item),
    .push_valid (fq_valid),
    .push_ready (fq_ready)
  );

  mm3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  mm3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_item  (qb_item),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // a full queue must back-pressure the input
  a_stall_reaches_input: assert property (@(posedge clk) disable iff (!rst_n)
    (fq_valid && !fq_ready) |-> !in_ch.ready)
    else $error("input accepted while front end is blocked");

  // a final beat occupies the back end for finalization
  a_last_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (qb_valid && qb_ready && qb_item.last) |=> !qb_ready)
    else $error("back end took a beat during finalization");

  // a result appears only out of the finalization sequence
  a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!qb_ready))
    else $error("result emitted without finalization");
`endif

endmodule
`default_nettype wire
